[hdl/meteor_rain_frame_engine_assert.svh]
// assertion macros shared by the meteor rain frame engine rtl
// expects signals clk and rst_n in the scope where a macro is used
`ifndef METEOR_RAIN_FRAME_ENGINE_ASSERT_SVH
`define METEOR_RAIN_FRAME_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MRFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MRFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mrfe_pkg.sv]
// shared types, codes and the channel fade function of the meteor rain engine
// no dependencies
package mrfe_pkg;

    // fixed field widths
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned PIX_W   = 3 * CHAN_W;
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned MASK_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // channels at or below this level go dark when faded
    localparam logic [CHAN_W-1:0] FADE_FLOOR = 8'd10;

    // item kinds
    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_RED    = 3'd0,
        CFG_GREEN  = 3'd1,
        CFG_BLUE   = 3'd2,
        CFG_LENGTH = 3'd3,
        CFG_DECAY  = 3'd4,
        CFG_RANDOM = 3'd5
    } cfg_idx_t;

    // one channel fade step: c - (c*d >> 8), dark at or below the floor
    function automatic logic [CHAN_W-1:0] fade_channel(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] d
    );
        logic [2*CHAN_W-1:0] prod;
        begin
            prod = {{CHAN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, d};
            if (c <= FADE_FLOOR)
            begin
                fade_channel = '0;
            end
            else
            begin
                fade_channel = c - prod[2*CHAN_W-1:CHAN_W];
            end
        end
    endfunction

endpackage

[hdl/mrfe_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mrfe_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/meteor_rain_frame_engine.sv]
// meteor rain frame engine: one item reads and emits every pixel, and an advance item
// of an unfinished run also fades and redraws it; pixels pass the store read, stage s1
// and the output beat register in order; one store read per pixel, one write per redrawn pixel
// the next item is taken while the last pixel beat still waits in the output register
// reset: config to defaults, frame position zero, all pixel valid bits cleared (store reads black)
// depends on mrfe_pkg, mrfe_ram and meteor_rain_frame_engine_assert.svh
`include "meteor_rain_frame_engine_assert.svh"

module meteor_rain_frame_engine #(
    parameter int unsigned PIXELS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // fade_mask[31:0]
    input  logic        s_tuser,   // op
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_index[4:0], pixel_red[12:5], pixel_green[20:13],
                                   // pixel_blue[28:21], zero fill[31:29]
    output logic        m_tlast,   // frame_last
    output logic        m_tuser,   // run_finished
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int unsigned IDXW   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int unsigned CNTW   = $clog2(PIXELS + 1);
    localparam int unsigned FRAMES = 2 * PIXELS;
    localparam int unsigned POSW   = $clog2(FRAMES + 1);
    localparam int unsigned CMPW   = (POSW > 8) ? POSW : 8;
    localparam int unsigned CW     = mrfe_pkg::CHAN_W;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(PIXELS - 1);

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    // configuration registers
    logic [CW-1:0] red_reg;
    logic [CW-1:0] green_reg;
    logic [CW-1:0] blue_reg;
    logic [CW-1:0] length_reg;
    logic [CW-1:0] decay_reg;
    logic          random_reg;

    // control and item registers
    state_t                      state_reg, state_next;
    logic [CNTW-1:0]             rd_cnt_reg, rd_cnt_next;
    logic                        s1_valid_reg, s1_valid_next;
    logic [IDXW-1:0]             s1_idx_reg, s1_idx_next;
    logic [POSW-1:0]             pos_reg, pos_next;
    logic [POSW-1:0]             pos_item_reg;
    logic                        op_reg;
    logic                        fin_reg;
    logic [mrfe_pkg::MASK_W-1:0] mask_reg;
    logic [PIXELS-1:0]           vld_reg, vld_next;

    // output beat registers
    logic                         out_valid_reg, out_valid_next;
    logic [IDXW-1:0]              out_idx_reg;
    logic [mrfe_pkg::PIX_W-1:0]   out_pix_reg;
    logic                         out_last_reg;
    logic                         out_fin_reg;

    // datapath
    logic                        accept;
    logic                        advance;
    logic                        load_out;
    logic                        rd_en;
    logic [IDXW-1:0]             rd_addr;
    logic                        wr_en;
    logic [mrfe_pkg::PIX_W-1:0]  ram_rdata;
    logic [mrfe_pkg::PIX_W-1:0]  cur_pix;
    logic [mrfe_pkg::PIX_W-1:0]  faded_pix;
    logic [mrfe_pkg::PIX_W-1:0]  new_pix;
    logic [mrfe_pkg::PIX_W-1:0]  emit_pix;
    logic [IDXW+4:0]             idx_ext;
    logic [IDXW+4:0]             out_idx_ext;
    logic                        fade_en;
    logic [POSW-1:0]             idx_pos;
    logic [POSW-1:0]             head_dist;
    logic                        in_meteor;
    logic                        updating;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign advance  = !out_valid_reg || m_tready;
    assign updating = (op_reg == mrfe_pkg::OP_ADVANCE) && !fin_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg    <= 8'd255;
            green_reg  <= 8'd255;
            blue_reg   <= 8'd255;
            length_reg <= 8'd10;
            decay_reg  <= 8'd64;
            random_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mrfe_pkg::CFG_RED:    red_reg    <= cfg_data;
                mrfe_pkg::CFG_GREEN:  green_reg  <= cfg_data;
                mrfe_pkg::CFG_BLUE:   blue_reg   <= cfg_data;
                mrfe_pkg::CFG_LENGTH: length_reg <= cfg_data;
                mrfe_pkg::CFG_DECAY:  decay_reg  <= cfg_data;
                mrfe_pkg::CFG_RANDOM: random_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // pixel store
    mrfe_ram #(
        .WIDTH (mrfe_pkg::PIX_W),
        .DEPTH (PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_idx_reg),
        .wdata (new_pix),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // fade and redraw of the pixel held in stage s1, and the value that is emitted for it
    always_comb
    begin
        idx_ext   = {5'b0, s1_idx_reg};
        cur_pix   = vld_reg[s1_idx_reg] ? ram_rdata : '0;
        fade_en   = !random_reg || mask_reg[idx_ext[4:0]];
        faded_pix = {mrfe_pkg::fade_channel(cur_pix[23:16], decay_reg),
                     mrfe_pkg::fade_channel(cur_pix[15:8], decay_reg),
                     mrfe_pkg::fade_channel(cur_pix[7:0], decay_reg)};
        idx_pos   = POSW'(s1_idx_reg);
        head_dist = pos_item_reg - idx_pos;
        in_meteor = (idx_pos <= pos_item_reg) && (CMPW'(head_dist) < CMPW'(length_reg));
        if (in_meteor)
        begin
            new_pix = {red_reg, green_reg, blue_reg};
        end
        else if (fade_en)
        begin
            new_pix = faded_pix;
        end
        else
        begin
            new_pix = cur_pix;
        end
        if (op_reg == mrfe_pkg::OP_START)
        begin
            emit_pix = '0;
        end
        else if (fin_reg)
        begin
            emit_pix = cur_pix;
        end
        else
        begin
            emit_pix = new_pix;
        end
    end

    // sweep sequencing: at most one read issued and one pixel retired per advancing cycle
    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        s1_valid_next  = s1_valid_reg;
        s1_idx_next    = s1_idx_reg;
        pos_next       = pos_reg;
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg && !m_tready;
        load_out       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = rd_cnt_reg[IDXW-1:0];
        wr_en          = 1'b0;

        if (accept)
        begin
            state_next  = ST_RUN;
            rd_cnt_next = '0;
            if (s_tuser == mrfe_pkg::OP_START)
            begin
                pos_next = '0;
                vld_next = '0;
            end
            else if (pos_reg < POSW'(FRAMES))
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else if (state_reg == ST_RUN && advance)
        begin
            if (s1_valid_reg)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
                if (updating)
                begin
                    wr_en                = 1'b1;
                    vld_next[s1_idx_reg] = 1'b1;
                end
            end
            if (rd_cnt_reg != CNTW'(PIXELS))
            begin
                rd_en         = 1'b1;
                s1_valid_next = 1'b1;
                s1_idx_next   = rd_cnt_reg[IDXW-1:0];
                rd_cnt_next   = rd_cnt_reg + 1'b1;
            end
            else
            begin
                s1_valid_next = 1'b0;
                if (s1_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s1_idx_reg    <= '0;
            pos_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= mrfe_pkg::OP_START;
            fin_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            s1_idx_reg    <= s1_idx_next;
            pos_reg       <= pos_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                op_reg  <= s_tuser;
                fin_reg <= (s_tuser == mrfe_pkg::OP_ADVANCE) && (pos_reg >= POSW'(FRAMES));
            end
        end
    end

    // item payload and output beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg     <= s_tdata;
            pos_item_reg <= pos_reg;
        end
        if (load_out)
        begin
            out_idx_reg  <= s1_idx_reg;
            out_pix_reg  <= emit_pix;
            out_last_reg <= (s1_idx_reg == LAST_IDX);
            out_fin_reg  <= fin_reg;
        end
    end

    // output stream
    assign out_idx_ext = {5'b0, out_idx_reg};
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {3'b0, out_pix_reg[7:0], out_pix_reg[15:8], out_pix_reg[23:16],
                          out_idx_ext[4:0]};
    assign m_tlast     = out_last_reg;
    assign m_tuser     = out_fin_reg;

    // checks
    `MRFE_ASSERT_NOW(a_s1_only_in_run, s1_valid_reg, state_reg == ST_RUN,
        "pixel in flight outside a frame sweep")
    `MRFE_ASSERT_NOW(a_pos_bounded, 1'b1, pos_reg <= POSW'(FRAMES),
        "frame position beyond the run length")
    `MRFE_ASSERT_NEXT(a_last_closes_sweep, load_out && s1_idx_reg == LAST_IDX,
        state_reg == ST_IDLE, "sweep did not end after the last pixel")
    `MRFE_ASSERT_NOW(a_no_write_when_frozen, wr_en, !fin_reg && op_reg == mrfe_pkg::OP_ADVANCE,
        "store written by a start or finished frame")

endmodule
